/* design/tlb2_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlb2_pkg: shared types and constants of the two-level TLB
// Field widths, request and response beats, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlb2_pkg;

    localparam int unsigned VPN_W  = 36;
    localparam int unsigned OFF_W  = 12;
    localparam int unsigned PAGE_W = 20;

    // One request beat.
    typedef struct packed {
        logic [VPN_W-1:0]  virt_page_number;
        logic [OFF_W-1:0]  page_offset;
        logic              access_is_data;
        logic [PAGE_W-1:0] walk_phys_page;
    } t_req;

    // One response beat.
    typedef struct packed {
        logic              hit;
        logic [PAGE_W-1:0] phys_page;
        logic [OFF_W-1:0]  phys_offset;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;     // write one invalid line into every table
        logic load_req;  // capture the accepted request
        logic lookup;    // read both L1s and L2 at the request's lines
        logic commit;    // update tables, load response, read other L1
        logic check;     // invalidate the other L1 line if its tag matches
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic l1_hit;
        logic l2_hit;
        logic victim_valid;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

/* design/tlb2_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlb2_req_if, tlb2_rsp_if: valid/ready channels of the two-level TLB
// A beat moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface tlb2_req_if;
    logic            valid;
    logic            ready;
    tlb2_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tlb2_rsp_if;
    logic            valid;
    logic            ready;
    tlb2_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/two_level_tlb_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_tlb_lookup: two-level direct-mapped TLB
// Instruction L1, data L1 and shared L2 lookup with fill on a walk result.
// ----------------------------------------------------------------------------
// After reset the block sweeps all three tables to invalid before the first
// request is taken. A request then passes through accept, table read and
// decide steps, and the decide step loads the response; it waits while the
// output register still holds an unaccepted response. A miss that displaces
// a valid L2 entry adds a check step after the decide step, which possibly
// invalidates the matching line of the other L1. These steps follow from the
// registered read ports of the table memories, each read in its own cycle.
// One request is in flight at a time; the response sits in an output
// register, so the next request is accepted while a response waits. Both
// line counts must be powers of two.
// ----------------------------------------------------------------------------
module two_level_tlb_lookup #(
    parameter int L1_LINES = 16,
    parameter int L2_LINES = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tlb2_req_if.sink    i_req,
    tlb2_rsp_if.source  o_rsp
);

    tlb2_pkg::t_cmd    cmd;
    tlb2_pkg::t_status status;
    logic              in_ready;

    tlb2_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    tlb2_dp #(
        .L1_LINES (L1_LINES),
        .L2_LINES (L2_LINES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req_data  (i_req.data),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data),
        .o_status    (status)
    );

    assign i_req.ready = in_ready;

endmodule
`default_nettype wire

/* design/tlb2_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlb2_ram: generic simple dual-port RAM
// One write port and one read port with registered read data that holds
// its value while no read is requested.
// ----------------------------------------------------------------------------
module tlb2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/tlb2_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlb2_ctrl: sequencer of the two-level TLB
// Runs the clearing sweep after reset, then steps each request through
// lookup, decision and the optional invalidation of the other L1.
// ----------------------------------------------------------------------------
module tlb2_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire tlb2_pkg::t_status i_status,
    output logic                   o_in_ready,
    output tlb2_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_CHECK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;

    // A full miss that displaces a valid L2 entry needs the extra check.
    logic need_check;
    assign need_check = !i_status.l1_hit && !i_status.l2_hit && i_status.victim_valid;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        o_cmd      = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_LOOKUP;
                    n_in_ready     = 1'b0;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    if (need_check) begin
                        n_state = S_CHECK;
                    end else begin
                        n_state    = S_IDLE;
                        n_in_ready = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_IDLE;
                n_in_ready  = 1'b1;
            end
            default: begin
                n_state    = S_CLEAR;
                n_in_ready = 1'b0;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

    // Requests are taken only between items, never during the sweep.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("ready raised outside the idle state");

    // The invalidation step always follows a commit of a full miss that displaces a valid L2 entry.
    a_check_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(o_cmd.commit && need_check))
        else $error("check step without a preceding full-miss commit");

    // A commit never overwrites a response that is still waiting.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_status.out_busy)
        else $error("commit while the output register is occupied");

endmodule
`default_nettype wire

/* design/tlb2_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlb2_dp: datapath of the two-level TLB
// Holds the request and response registers, the three table memories,
// the clearing counter and the hit, fill and invalidate logic.
// ----------------------------------------------------------------------------
module tlb2_dp #(
    parameter int L1_LINES = 16,
    parameter int L2_LINES = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tlb2_pkg::t_cmd  i_cmd,
    input  wire tlb2_pkg::t_req  i_req_data,
    input  wire logic            i_rsp_ready,
    output logic                 o_rsp_valid,
    output tlb2_pkg::t_rsp       o_rsp_data,
    output tlb2_pkg::t_status    o_status
);

    localparam int VPN_W     = tlb2_pkg::VPN_W;
    localparam int PAGE_W    = tlb2_pkg::PAGE_W;
    localparam int L1_IDX_W  = $clog2(L1_LINES);
    localparam int L1_TAG_W  = VPN_W - L1_IDX_W;
    localparam int L1_WORD_W = 1 + L1_TAG_W + PAGE_W;
    localparam int L2_IDX_W  = $clog2(L2_LINES);
    localparam int L2_TAG_W  = VPN_W - L2_IDX_W;
    localparam int L2_WORD_W = 1 + L2_TAG_W + PAGE_W;
    localparam int CLR_LINES = (L2_LINES > L1_LINES) ? L2_LINES : L1_LINES;
    localparam int CLR_W     = $clog2(CLR_LINES);

    tlb2_pkg::t_req r_req;
    tlb2_pkg::t_rsp r_rsp;
    logic           r_rsp_valid;
    logic [CLR_W-1:0] r_clr_cnt;

    logic [L1_WORD_W-1:0] instr_rdata;
    logic [L1_WORD_W-1:0] data_rdata;
    logic [L2_WORD_W-1:0] l2_rdata;

    // Request fields split into line index and tag for each level.
    logic [L1_IDX_W-1:0] l1_idx;
    logic [L1_TAG_W-1:0] l1_tag;
    logic [L2_IDX_W-1:0] l2_idx;
    logic [L2_TAG_W-1:0] l2_tag;
    logic                is_data;

    assign l1_idx  = r_req.virt_page_number[L1_IDX_W-1:0];
    assign l1_tag  = r_req.virt_page_number[VPN_W-1:L1_IDX_W];
    assign l2_idx  = r_req.virt_page_number[L2_IDX_W-1:0];
    assign l2_tag  = r_req.virt_page_number[VPN_W-1:L2_IDX_W];
    assign is_data = r_req.access_is_data;

    // Own and other L1 words as seen by this request.
    logic [L1_WORD_W-1:0] own_word;
    logic [L1_WORD_W-1:0] other_word;
    assign own_word   = is_data ? data_rdata : instr_rdata;
    assign other_word = is_data ? instr_rdata : data_rdata;

    // Hit detection on both levels.
    logic              l1_hit;
    logic              l2_hit;
    logic              victim_valid;
    logic [PAGE_W-1:0] own_page;
    logic [PAGE_W-1:0] l2_page;
    logic [PAGE_W-1:0] fill_page;

    assign l1_hit       = own_word[L1_WORD_W-1] &&
                          (own_word[L1_WORD_W-2:PAGE_W] == l1_tag);
    assign victim_valid = l2_rdata[L2_WORD_W-1];
    assign l2_hit       = victim_valid && (l2_rdata[L2_WORD_W-2:PAGE_W] == l2_tag);
    assign own_page     = own_word[PAGE_W-1:0];
    assign l2_page      = l2_rdata[PAGE_W-1:0];
    assign fill_page    = l2_hit ? l2_page : r_req.walk_phys_page;

    // Page of the displaced L2 entry and its line in the other L1.
    logic [VPN_W-1:0]    old_vpn;
    logic [L1_IDX_W-1:0] o_idx;
    logic [L1_TAG_W-1:0] o_tag;
    logic                other_match;

    assign old_vpn     = {l2_rdata[L2_WORD_W-2:PAGE_W], l2_idx};
    assign o_idx       = old_vpn[L1_IDX_W-1:0];
    assign o_tag       = old_vpn[VPN_W-1:L1_IDX_W];
    assign other_match = (other_word[L1_WORD_W-2:PAGE_W] == o_tag);

    // Control of the two L1 memories.
    logic                 l1_fill;
    logic [L1_IDX_W-1:0]  l1_waddr;
    logic [L1_IDX_W-1:0]  l1_raddr;
    logic                 l1_re;
    logic [L1_WORD_W-1:0] l1_fill_word;
    logic [L1_WORD_W-1:0] l1_kill_word;
    logic [L1_WORD_W-1:0] l1_wdata_own;
    logic [L1_WORD_W-1:0] l1_wdata_other;
    logic                 instr_we;
    logic                 data_we;
    logic [L1_WORD_W-1:0] instr_wdata;
    logic [L1_WORD_W-1:0] data_wdata;

    assign l1_fill      = i_cmd.commit && !l1_hit;
    assign l1_waddr     = i_cmd.clear ? r_clr_cnt[L1_IDX_W-1:0] :
                          (i_cmd.commit ? l1_idx : o_idx);
    assign l1_raddr     = i_cmd.lookup ? l1_idx : o_idx;
    assign l1_re        = i_cmd.lookup || i_cmd.commit;
    assign l1_fill_word = {1'b1, l1_tag, fill_page};
    assign l1_kill_word = {1'b0, other_word[L1_WORD_W-2:0]};
    assign l1_wdata_own   = i_cmd.clear ? '0 : l1_fill_word;
    assign l1_wdata_other = i_cmd.clear ? '0 : l1_kill_word;

    assign instr_we    = i_cmd.clear || (l1_fill && !is_data) ||
                         (i_cmd.check && is_data && other_match);
    assign data_we     = i_cmd.clear || (l1_fill && is_data) ||
                         (i_cmd.check && !is_data && other_match);
    assign instr_wdata = (i_cmd.check && is_data) ? l1_wdata_other : l1_wdata_own;
    assign data_wdata  = (i_cmd.check && !is_data) ? l1_wdata_other : l1_wdata_own;

    // Control of the L2 memory.
    logic                 l2_we;
    logic [L2_IDX_W-1:0]  l2_addr;
    logic [L2_WORD_W-1:0] l2_wdata;

    assign l2_we    = i_cmd.clear || (i_cmd.commit && !l1_hit && !l2_hit);
    assign l2_addr  = i_cmd.clear ? r_clr_cnt[L2_IDX_W-1:0] : l2_idx;
    assign l2_wdata = i_cmd.clear ? '0 : {1'b1, l2_tag, r_req.walk_phys_page};

    tlb2_ram #(.WIDTH(L1_WORD_W), .DEPTH(L1_LINES)) u_instr_l1 (
        .i_clk   (i_clk),
        .i_we    (instr_we),
        .i_waddr (l1_waddr),
        .i_wdata (instr_wdata),
        .i_re    (l1_re),
        .i_raddr (l1_raddr),
        .o_rdata (instr_rdata)
    );

    tlb2_ram #(.WIDTH(L1_WORD_W), .DEPTH(L1_LINES)) u_data_l1 (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (l1_waddr),
        .i_wdata (data_wdata),
        .i_re    (l1_re),
        .i_raddr (l1_raddr),
        .o_rdata (data_rdata)
    );

    tlb2_ram #(.WIDTH(L2_WORD_W), .DEPTH(L2_LINES)) u_shared_l2 (
        .i_clk   (i_clk),
        .i_we    (l2_we),
        .i_waddr (l2_addr),
        .i_wdata (l2_wdata),
        .i_re    (i_cmd.lookup),
        .i_raddr (l2_idx),
        .o_rdata (l2_rdata)
    );

    // Clearing sweep counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_data;
        end
    end

    // Response register; a new beat may load as the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp.hit         <= l1_hit || l2_hit;
            r_rsp.phys_page   <= l1_hit ? own_page : fill_page;
            r_rsp.phys_offset <= r_req.page_offset;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp_data  = r_rsp;

    // Status back to the controller.
    always_comb begin
        o_status.clear_done   = (r_clr_cnt == CLR_W'(CLR_LINES - 1));
        o_status.l1_hit       = l1_hit;
        o_status.l2_hit       = l2_hit;
        o_status.victim_valid = victim_valid;
        o_status.out_busy     = r_rsp_valid && !i_rsp_ready;
    end

    // A commit that fills L2 must also fill the own L1.
    a_fill_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && l2_we) |-> (instr_we || data_we))
        else $error("L2 filled without an L1 fill");

    // The invalidation step never writes the L1 of the access kind.
    a_kill_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.check |-> !(is_data ? data_we : instr_we))
        else $error("invalidation hit the own L1");

    // A response is loaded by each commit and is valid in the next cycle.
    a_rsp_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_rsp_valid)
        else $error("commit did not produce a response");

endmodule
`default_nettype wire

/* bench/tb_two_level_tlb_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_tlb_lookup: self-checking bench for the two-level TLB
// A table of directed requests covers cold misses, L1 and L2 hits, and the
// eviction of a displaced L2 page from the other L1. About twelve hundred
// random requests then follow, drawn from a small pool of pages so that hits
// and line conflicts are common. Every accepted request runs through a local
// model of the three tables. Every response beat is compared field by field
// with the oldest pending translation.
// ----------------------------------------------------------------------------
module tb_two_level_tlb_lookup;

    localparam int VPN_W        = tlb2_pkg::VPN_W;
    localparam int OFF_W        = tlb2_pkg::OFF_W;
    localparam int PAGE_W       = tlb2_pkg::PAGE_W;
    localparam int L1_LINES     = 16;
    localparam int L2_LINES     = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS  = 400;
    localparam int POOL_SIZE    = 32;

    // Access kinds carried by access_is_data.
    localparam logic INSTR = 1'b0;
    localparam logic DATA  = 1'b1;

    // Receiver stall patterns.
    typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        logic              valid;
        logic [VPN_W-1:0]  tag;
        logic [PAGE_W-1:0] page;
    } t_tlb_line;

    typedef struct {
        tlb2_pkg::t_req req;
        logic           known;
        tlb2_pkg::t_rsp rsp;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlb2_req_if req_ch ();
    tlb2_rsp_if rsp_ch ();

    two_level_tlb_lookup #(
        .L1_LINES(L1_LINES),
        .L2_LINES(L2_LINES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Local copy of the tables; index 0 of l1_lines is the instruction L1.
    t_tlb_line l1_lines [2][L1_LINES];
    t_tlb_line l2_lines [L2_LINES];

    tlb2_pkg::t_rsp   translation_q[$];
    t_dir_row         dir_rows[$];
    logic [VPN_W-1:0] recent_vpns [POOL_SIZE];

    // A directed row may carry its response, sent along with the beat.
    logic           req_known;
    tlb2_pkg::t_rsp req_known_rsp;

    int fail_count  = 0;
    int n_beats_out = 0;
    int n_l1_hits   = 0;
    int n_l2_hits   = 0;
    int n_walks     = 0;
    int n_evictions = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int bursty      = 1;
    int hold_ask    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int rx_left     = 0;
    int rx_tick     = 0;
    t_rx_mode rx_mode = RX_ALWAYS;

    always #4 i_clk = ~i_clk;

    // Translate one request through the local tables and update them.
    function automatic tlb2_pkg::t_rsp translate_vpn(input tlb2_pkg::t_req r);
        tlb2_pkg::t_rsp res;
        logic [VPN_W-1:0] vpn;
        logic [VPN_W-1:0] l1_tag;
        logic [VPN_W-1:0] l2_tag;
        logic [VPN_W-1:0] old_vpn;
        int unsigned l1_idx;
        int unsigned l2_idx;
        int unsigned old_idx;
        int unsigned own;
        int unsigned other;
        logic had_victim;
        vpn    = r.virt_page_number;
        own    = (r.access_is_data == DATA) ? 1 : 0;
        other  = 1 - own;
        l1_idx = vpn % L1_LINES;
        l1_tag = vpn / L1_LINES;
        l2_idx = vpn % L2_LINES;
        l2_tag = vpn / L2_LINES;
        res.phys_offset = r.page_offset;
        if (l1_lines[own][l1_idx].valid && l1_lines[own][l1_idx].tag == l1_tag) begin
            res.hit       = 1'b1;
            res.phys_page = l1_lines[own][l1_idx].page;
            n_l1_hits++;
        end else if (l2_lines[l2_idx].valid && l2_lines[l2_idx].tag == l2_tag) begin
            // The other L1 is left alone on an L2 hit.
            res.hit       = 1'b1;
            res.phys_page = l2_lines[l2_idx].page;
            l1_lines[own][l1_idx] = '{1'b1, l1_tag, res.phys_page};
            n_l2_hits++;
        end else begin
            res.hit       = 1'b0;
            res.phys_page = r.walk_phys_page;
            had_victim    = l2_lines[l2_idx].valid;
            old_vpn       = l2_lines[l2_idx].tag * L2_LINES + l2_idx;
            l2_lines[l2_idx]      = '{1'b1, l2_tag, res.phys_page};
            l1_lines[own][l1_idx] = '{1'b1, l1_tag, res.phys_page};
            n_walks++;
            // The displaced page leaves the other L1 when its tag is found
            // there, whether or not that line was valid.
            if (had_victim) begin
                old_idx = old_vpn % L1_LINES;
                if (l1_lines[other][old_idx].tag == old_vpn / L1_LINES) begin
                    l1_lines[other][old_idx].valid = 1'b0;
                    n_evictions++;
                end
            end
        end
        return res;
    endfunction

    // Draw a page number that often hits or collides with recent pages.
    function automatic logic [VPN_W-1:0] pick_vpn();
        logic [VPN_W-1:0] base;
        logic [VPN_W-1:0] upper;
        logic [VPN_W-1:0] vpn;
        int unsigned roll;
        base  = recent_vpns[$urandom_range(0, POOL_SIZE - 1)];
        upper = ($urandom_range(0, 1) == 0) ? VPN_W'($urandom_range(0, 3))
                                            : VPN_W'({$urandom(), $urandom()});
        roll  = $urandom_range(0, 99);
        if (roll < 40) begin
            vpn = base;
        end else if (roll < 65) begin
            // Same L2 line, possibly a new tag that displaces a page.
            vpn = {upper[VPN_W-7:0], base[5:0]};
        end else if (roll < 80) begin
            // Same L1 line, possibly a different L2 line.
            vpn = {base[VPN_W-1:6], 2'($urandom_range(0, 3)), base[3:0]};
        end else if (roll < 90) begin
            vpn = VPN_W'($urandom_range(0, 255));
        end else begin
            vpn = VPN_W'({$urandom(), $urandom()});
        end
        recent_vpns[$urandom_range(0, POOL_SIZE - 1)] = vpn;
        return vpn;
    endfunction

    function automatic tlb2_pkg::t_req random_request();
        tlb2_pkg::t_req r;
        r.virt_page_number = pick_vpn();
        r.page_offset      = OFF_W'($urandom());
        r.access_is_data   = 1'($urandom_range(0, 1));
        r.walk_phys_page   = ($urandom_range(0, 9) == 0) ? '1 : PAGE_W'($urandom());
        return r;
    endfunction

    task automatic add_row(input logic [VPN_W-1:0] vpn, input logic [OFF_W-1:0] off,
                           input logic kind, input logic [PAGE_W-1:0] walk,
                           input logic known, input logic hit,
                           input logic [PAGE_W-1:0] page);
        t_dir_row row;
        row.req   = '{vpn, off, kind, walk};
        row.known = known;
        row.rsp   = '{hit, page, off};
        dir_rows.push_back(row);
    endtask

    // Offer one request beat; the sender works in bursts, with gaps between them while bursty is set.
    task automatic offer_beat(input tlb2_pkg::t_req r, input logic known,
                              input tlb2_pkg::t_rsp k);
        int gap;
        if (burst_left == 0) begin
            gap        = bursty ? $urandom_range(0, 8) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid  <= 1'b1;
        req_ch.data   <= r;
        req_known     <= known;
        req_known_rsp <= k;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Lower valid and wait until every pending translation has come back.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (translation_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: random stall patterns, plus one long hold-off on request.
    always @(posedge i_clk) begin
        rx_tick++;
        if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_ALWAYS:   rsp_ch.ready <= 1'b1;
                RX_HALF:     rsp_ch.ready <= ($urandom_range(0, 1) == 0);
                RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default:     rsp_ch.ready <= (rx_tick % 4 != 3);
            endcase
        end
    end

    // Beat monitor: check responses first, then record accepted requests.
    always @(posedge i_clk) begin : beat_monitor
        tlb2_pkg::t_rsp want;
        tlb2_pkg::t_rsp got;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.data;
                n_beats_out++;
                if (translation_q.size() == 0) begin
                    $display("%0t: response beat with nothing pending, expected none, actual %h",
                             $realtime, got);
                    fail_count++;
                end else begin
                    want = translation_q.pop_front();
                    check_field("hit", 32'(want.hit), 32'(got.hit));
                    check_field("phys_page", 32'(want.phys_page), 32'(got.phys_page));
                    check_field("phys_offset", 32'(want.phys_offset), 32'(got.phys_offset));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                // The local tables advance on every request, typed rows too.
                want = translate_vpn(req_ch.data);
                if (req_known) begin
                    want = req_known_rsp;
                end
                translation_q.push_back(want);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d translations pending",
                     $realtime, translation_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        tlb2_pkg::t_rsp no_rsp;
        no_rsp        = '0;
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        req_known     = 1'b0;
        req_known_rsp = '0;
        for (int k = 0; k < L1_LINES; k++) begin
            l1_lines[0][k] = '0;
            l1_lines[1][k] = '0;
        end
        for (int k = 0; k < L2_LINES; k++) begin
            l2_lines[k] = '0;
        end
        for (int k = 0; k < POOL_SIZE; k++) begin
            recent_vpns[k] = VPN_W'($urandom_range(0, 127));
        end

        // Directed table: vpn, offset, kind, walk, typed?, hit, page.
        // Cold miss, then L1 hit that ignores the walk, then L2 hit into data L1, then data L1 hit.
        add_row(36'h000000000, 12'h000, INSTR, 20'h00000, 1, 0, 20'h00000);
        add_row(36'h000000000, 12'hFFF, INSTR, 20'hFFFFF, 1, 1, 20'h00000);
        add_row(36'h000000000, 12'h123, DATA,  20'h12345, 1, 1, 20'h00000);
        add_row(36'h000000000, 12'h800, DATA,  20'h00000, 1, 1, 20'h00000);
        // Top of the page range, then an L2 hit from the other side.
        add_row(36'hFFFFFFFFF, 12'hFFF, DATA,  20'hFFFFF, 1, 0, 20'hFFFFF);
        add_row(36'hFFFFFFFFF, 12'h000, INSTR, 20'h00000, 1, 1, 20'hFFFFF);
        // Displacing page 0 drops it from the data L1, so page 0 then misses.
        add_row(36'h000000040, 12'h555, INSTR, 20'hAAAAA, 1, 0, 20'hAAAAA);
        add_row(36'h000000000, 12'hAAA, DATA,  20'h55555, 1, 0, 20'h55555);
        add_row(36'h000000040, 12'h000, INSTR, 20'h0F0F0, 0, 0, 20'h00000);
        // A displaced page whose L1 line holds another tag stays untouched.
        add_row(36'h000000010, 12'h000, DATA,  20'h01234, 0, 0, 20'h00000);
        add_row(36'h000000010, 12'h000, INSTR, 20'h00000, 0, 0, 20'h00000);
        add_row(36'h000000020, 12'h000, INSTR, 20'h00000, 0, 0, 20'h00000);
        add_row(36'h000000050, 12'h000, DATA,  20'h0BEEF, 0, 0, 20'h00000);
        add_row(36'h000000020, 12'h000, INSTR, 20'h00000, 0, 0, 20'h00000);
        // Alternating bit patterns on fresh lines.
        add_row(36'hAAAAAAAAA, 12'hAAA, DATA,  20'hAAAAA, 1, 0, 20'hAAAAA);
        add_row(36'h555555555, 12'h555, INSTR, 20'h55555, 1, 0, 20'h55555);
        add_row(36'hAAAAAAAAA, 12'h000, INSTR, 20'h00000, 0, 0, 20'h00000);
        add_row(36'h555555555, 12'h000, DATA,  20'h00000, 0, 0, 20'h00000);
        // Back-to-back on one line.
        add_row(36'hFFFFFFFC0, 12'h000, DATA,  20'h12321, 0, 0, 20'h00000);
        add_row(36'hFFFFFFFC0, 12'h001, DATA,  20'h00000, 0, 0, 20'h00000);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            offer_beat(dir_rows[k].req, dir_rows[k].known, dir_rows[k].rsp);
        end

        // Random traffic with bursty sender.
        repeat (PHASE_ITEMS) offer_beat(random_request(), 1'b0, no_rsp);

        // Long receiver hold-off while requests keep coming.
        hold_ask++;
        repeat (PHASE_ITEMS) offer_beat(random_request(), 1'b0, no_rsp);

        // Sender pauses until everything is back, then streams without gaps.
        drain_responses();
        bursty = 0;
        repeat (PHASE_ITEMS) offer_beat(random_request(), 1'b0, no_rsp);

        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d responses: %0d L1 hits, %0d L2 hits, %0d walks.",
                 n_beats_out, n_l1_hits, n_l2_hits, n_walks);
        $display("Displaced pages dropped from the other L1: %0d; %0d mismatches.",
                 n_evictions, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* two_level_tlb_lookup.f */
design/tlb2_pkg.sv
design/tlb2_if.sv
design/tlb2_ram.sv
design/tlb2_ctrl.sv
design/tlb2_dp.sv
design/two_level_tlb_lookup.sv
bench/tb_two_level_tlb_lookup.sv
